>>> hw/rtl/positional_array_list_core_defines.svh
// ----------------------------------------------------------------------------
// Positional array list core: assertion macros
// Shared property forms for the port checker. Clock is clk, reset is rst.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_CORE_DEFINES_SVH

// Same-cycle implication, quiet during reset.
`define APL_ASSERT_HOLD(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define APL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers reset cycles.
`define APL_ASSERT_NEXT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/apl_pkg.sv
// ----------------------------------------------------------------------------
// Positional array list package
// Request and response types, operation and status codes, and the
// controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apl_pkg;

  localparam logic [2:0] MODE_READ   = 3'd0;
  localparam logic [2:0] MODE_FIND   = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic [7:0]         position;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         found_index;
    logic [7:0]         list_length;
  } rsp_t;

  // What the latched request needs from the datapath after its checks.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FIND,
    ACT_UP,
    ACT_DOWN,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    logic load;
    logic decide;
    logic step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic done;
  } sts_t;

endpackage

>>> hw/rtl/apl_datapath.sv
// ----------------------------------------------------------------------------
// Positional array list datapath
// Entry memory, count, request registers, walk pointer and response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apl_datapath #(
  parameter int CAPACITY = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  apl_pkg::req_t req,
  input  apl_pkg::cmd_t cmd,
  output apl_pkg::sts_t sts,
  output apl_pkg::rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  logic signed [31:0] mem [CAPACITY];

  logic [2:0]         mode;
  logic [7:0]         position;
  logic signed [31:0] value;
  logic [CW-1:0]      count;
  logic [CW-1:0]      ptr;
  logic [AW-1:0]      dest;
  logic               pend;
  logic signed [31:0] rdata;
  logic [1:0]         status;
  logic [AW-1:0]      found;

  logic [XW-1:0]      pos_x;
  logic [XW-1:0]      pos_m1;
  logic [XW-1:0]      count_x;
  logic [XW-1:0]      ptr_x;
  logic [XW-1:0]      found_x;
  logic [CW-1:0]      ptr_m1;
  apl_pkg::act_t      act;
  logic [1:0]         pre_status;
  logic               hit;
  logic               issue;
  logic               done;
  logic [AW-1:0]      rd_addr;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  assign pos_x   = {{(XW-8){1'b0}}, position};
  assign pos_m1  = pos_x - 1'b1;
  assign count_x = {{(XW-CW){1'b0}}, count};
  assign ptr_x   = {{(XW-CW){1'b0}}, ptr};
  assign found_x = {{(XW-AW){1'b0}}, found};
  assign ptr_m1  = ptr - 1'b1;
  assign hit     = pend && (rdata == value);

  // Range and capacity checks on the latched request.
  always_comb begin
    act        = apl_pkg::ACT_NONE;
    pre_status = apl_pkg::ST_OK;
    case (mode)
      apl_pkg::MODE_READ: begin
        if (pos_x >= count_x) pre_status = apl_pkg::ST_RANGE;
      end
      apl_pkg::MODE_FIND: begin
        act        = apl_pkg::ACT_FIND;
        pre_status = apl_pkg::ST_NOTFOUND;
      end
      apl_pkg::MODE_INSERT: begin
        if (pos_x == '0 || pos_x > count_x + 1'b1) begin
          pre_status = apl_pkg::ST_RANGE;
        end else if (count_x >= XW'(CAPACITY)) begin
          pre_status = apl_pkg::ST_FULL;
        end else begin
          act = apl_pkg::ACT_UP;
        end
      end
      apl_pkg::MODE_DELETE: begin
        if (pos_x == '0 || pos_x > count_x) pre_status = apl_pkg::ST_RANGE;
        else act = apl_pkg::ACT_DOWN;
      end
      apl_pkg::MODE_CLEAR: act = apl_pkg::ACT_CLEAR;
      default: ;
    endcase
  end

  // Walk control: up moves entries from the tail toward position, down from
  // position toward the tail; find scans from the head.
  always_comb begin
    issue   = 1'b0;
    done    = 1'b1;
    rd_addr = pos_x[AW-1:0];
    case (act)
      apl_pkg::ACT_FIND: begin
        issue   = ptr_x < count_x;
        done    = hit || (ptr_x >= count_x);
        rd_addr = ptr[AW-1:0];
      end
      apl_pkg::ACT_UP: begin
        issue   = ptr_x >= pos_x;
        done    = !pend && (ptr_x < pos_x);
        rd_addr = ptr_m1[AW-1:0];
      end
      apl_pkg::ACT_DOWN: begin
        issue   = ptr_x < count_x;
        done    = !pend && (ptr_x >= count_x);
        rd_addr = ptr[AW-1:0];
      end
      default: ;
    endcase
  end

  assign we = (cmd.step && pend &&
               (act == apl_pkg::ACT_UP || act == apl_pkg::ACT_DOWN)) ||
              (cmd.commit && act == apl_pkg::ACT_UP);
  assign waddr = cmd.commit ? pos_m1[AW-1:0] : dest;
  assign wdata = cmd.commit ? value : rdata;

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      pend  <= 1'b0;
    end else begin
      if (cmd.decide) pend <= 1'b0;
      if (cmd.step) pend <= issue;
      if (cmd.commit) begin
        case (act)
          apl_pkg::ACT_UP:    count <= count + 1'b1;
          apl_pkg::ACT_DOWN:  count <= count - 1'b1;
          apl_pkg::ACT_CLEAR: count <= '0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode     <= req.mode;
      position <= req.position;
      value    <= req.value;
    end
    if (cmd.decide) begin
      status <= pre_status;
      found  <= '0;
      case (act)
        apl_pkg::ACT_FIND: ptr <= '0;
        apl_pkg::ACT_UP:   ptr <= count;
        apl_pkg::ACT_DOWN: ptr <= pos_x[CW-1:0];
        default: ;
      endcase
    end
    if (cmd.step) begin
      if (issue) begin
        if (act == apl_pkg::ACT_UP) begin
          dest <= ptr[AW-1:0];
          ptr  <= ptr_m1;
        end else if (act == apl_pkg::ACT_DOWN) begin
          dest <= ptr_m1[AW-1:0];
          ptr  <= ptr + 1'b1;
        end else begin
          dest <= ptr[AW-1:0];
          ptr  <= ptr + 1'b1;
        end
      end
      // dest still names the entry that rdata came from
      if (act == apl_pkg::ACT_FIND && hit) begin
        status <= apl_pkg::ST_OK;
        found  <= dest;
      end
    end
    if (cmd.emit) begin
      rsp.status      <= status;
      rsp.read_value  <= (mode == apl_pkg::MODE_READ && status == apl_pkg::ST_OK) ?
                         rdata : 32'sd0;
      rsp.found_index <= found_x[6:0];
      rsp.list_length <= count_x[7:0];
    end
  end

  assign sts.act  = act;
  assign sts.done = done;

endmodule

>>> hw/rtl/apl_ctrl.sv
// ----------------------------------------------------------------------------
// Positional array list controller
// Sequences one transaction at a time through check, walk, commit and reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output apl_pkg::cmd_t cmd,
  input  apl_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_WALK,
    S_COMMIT,
    S_RESP
  } state_t;

  state_t state;
  logic   can_emit;

  assign can_emit  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && req_valid;
    cmd.decide = (state == S_DECIDE);
    cmd.step   = (state == S_WALK);
    cmd.commit = (state == S_COMMIT);
    cmd.emit   = (state == S_RESP) && can_emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.emit) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          case (sts.act)
            apl_pkg::ACT_NONE:  state <= S_RESP;
            apl_pkg::ACT_CLEAR: state <= S_COMMIT;
            default:            state <= S_WALK;
          endcase
        end
        S_WALK: begin
          if (sts.done) state <= S_COMMIT;
        end
        S_COMMIT: state <= S_RESP;
        S_RESP: begin
          // hold until the output register is free
          if (can_emit) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/positional_array_list_core.sv
// ----------------------------------------------------------------------------
// Positional array list core
// Ordered list of signed 32-bit entries with read, find, insert, delete and
// clear requests; one response per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req/req_valid/req_stall, responses leave on
//   rsp/rsp_valid/rsp_stall. A transaction moves when valid is high and
//   stall is low. One request is worked on at a time; req_stall is high from
//   the cycle after acceptance until the response is loaded.
//   Read, rejected and unused requests go from the checks straight to the
//   reply; clear adds a commit step. A walk goes over the entry memory (one
//   read and one write port) one entry per cycle: find reads up to length
//   entries, insert moves the entries from position to the tail, delete
//   those after position. The next request can be accepted in the cycle
//   after the response is loaded, even while that response is still
//   stalled. A walk of CAPACITY entries sets the worst case.
//   Reset empties the list (length zero) and drops any pending response;
//   entry memory is not cleared and needs no sweep. A stalled response
//   holds in the output register and the block waits before loading the next.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_array_list_core #(
  parameter int CAPACITY = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  apl_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output apl_pkg::rsp_t rsp
);

  apl_pkg::cmd_t cmd;
  apl_pkg::sts_t sts;

  apl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  apl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

>>> hw/rtl/apl_checker.sv
// ----------------------------------------------------------------------------
// Positional array list port checker
// Watches the top-level ports for response and sequencing rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_array_list_core_defines.svh"

module apl_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input apl_pkg::rsp_t rsp
);

  `APL_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
  `APL_ASSERT_HOLD(a_rd_zero, rsp_valid && rsp.status != apl_pkg::ST_OK, rsp.read_value == 32'sd0, "read value set on failed request")
  `APL_ASSERT_HOLD(a_nf_idx, rsp_valid && rsp.status == apl_pkg::ST_NOTFOUND, rsp.found_index == 7'd0, "index set on missed find")
  `APL_ASSERT_NEXT(a_one_open, req_valid && !req_stall, req_stall, "second request taken while busy")
  `APL_ASSERT_NEXT_RST(a_rst_quiet, rst, !rsp_valid, "response valid after reset")

endmodule

bind positional_array_list_core apl_checker u_apl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional array list core testbench
// Drives read, find, insert, delete, clear and unused requests with random
// gaps on the request side and random stalls on the response side. A shadow
// list in the bench predicts every response, and each response is compared
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int         CAPACITY          = 128;
  localparam int         POS_MAX           = 255;
  localparam logic [2:0] MODE_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] MODE_UNUSED_LAST  = 3'd7;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  apl_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  apl_pkg::rsp_t rsp;

  logic signed [31:0] shadow_list[$];
  apl_pkg::rsp_t      replies_due[$];
  int                 error_count  = 0;
  bit                 idle_enabled = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  positional_array_list_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  function automatic int draw_idle();
    return idle_enabled ? $urandom_range(0, 8) : 0;
  endfunction

  // Apply one request to the shadow list and return the response it must give.
  function automatic apl_pkg::rsp_t apply_list_request(apl_pkg::req_t r);
    apl_pkg::rsp_t o;
    int            k;
    bit            hit;
    o   = '0;
    hit = 1'b0;
    case (r.mode)
      apl_pkg::MODE_READ: begin
        if (r.position < shadow_list.size()) o.read_value = shadow_list[r.position];
        else o.status = apl_pkg::ST_RANGE;
      end
      apl_pkg::MODE_FIND: begin
        o.status = apl_pkg::ST_NOTFOUND;
        for (k = 0; k < shadow_list.size(); k++) begin
          if (!hit && shadow_list[k] == r.value) begin
            hit           = 1'b1;
            o.found_index = 7'(k);
            o.status      = apl_pkg::ST_OK;
          end
        end
      end
      apl_pkg::MODE_INSERT: begin
        if (r.position == 0 || r.position > shadow_list.size() + 1)
          o.status = apl_pkg::ST_RANGE;
        else if (shadow_list.size() >= CAPACITY)
          o.status = apl_pkg::ST_FULL;
        else
          shadow_list.insert(r.position - 1, r.value);
      end
      apl_pkg::MODE_DELETE: begin
        if (r.position == 0 || r.position > shadow_list.size())
          o.status = apl_pkg::ST_RANGE;
        else
          shadow_list.delete(r.position - 1);
      end
      apl_pkg::MODE_CLEAR: shadow_list.delete();
      default: ;
    endcase
    o.list_length = 8'(shadow_list.size());
    return o;
  endfunction

  // Pick a search value: half the time one already in the list (when it is not empty), so finds can hit.
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 3);
    if (sel < 2 && shadow_list.size() != 0)
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    if (sel == 2) return $urandom_range(0, 15);
    return $urandom();
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  // Send one request; called at a rising edge, returns at its acceptance edge.
  task automatic issue_request(logic [2:0] mode, int position, logic signed [31:0] value);
    apl_pkg::req_t item;
    int            gap;
    item.mode     = mode;
    item.position = position[7:0];
    item.value    = value;
    gap           = draw_idle();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall !== 1'b0);
    replies_due.push_back(apply_list_request(item));
  endtask

  task automatic wait_for_replies();
    req_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin : check_replies
    apl_pkg::rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (replies_due.size() == 0) begin
        report_mismatch("response with none pending", 64'(rsp), 64'd0);
      end else begin
        want = replies_due.pop_front();
        if (rsp.status !== want.status)
          report_mismatch("status", 64'(rsp.status), 64'(want.status));
        if (rsp.read_value !== want.read_value)
          report_mismatch("read_value", 64'(rsp.read_value), 64'(want.read_value));
        if (rsp.found_index !== want.found_index)
          report_mismatch("found_index", 64'(rsp.found_index), 64'(want.found_index));
        if (rsp.list_length !== want.list_length)
          report_mismatch("list_length", 64'(rsp.list_length), 64'(want.list_length));
      end
    end
  end

  // Raise rsp_stall for a random draw_idle() gap, then take the next response.
  initial begin : drive_rsp_stall
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = draw_idle();
      if (hold > 0) begin
        rsp_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (rsp_valid !== 1'b1);
    end
  end

  task automatic test_empty_list();
    issue_request(apl_pkg::MODE_READ, 0, 0);
    issue_request(apl_pkg::MODE_FIND, 0, 0);
    issue_request(apl_pkg::MODE_DELETE, 1, 0);
    issue_request(apl_pkg::MODE_INSERT, 0, 32'sd5);
    issue_request(apl_pkg::MODE_INSERT, 2, 32'sd5);
    issue_request(apl_pkg::MODE_CLEAR, 0, 0);
  endtask

  task automatic test_field_extremes();
    issue_request(apl_pkg::MODE_INSERT, 1, 32'sh8000_0000);
    issue_request(apl_pkg::MODE_INSERT, 2, 32'sh7fff_ffff);
    issue_request(apl_pkg::MODE_INSERT, 1, -32'sd1);
    issue_request(apl_pkg::MODE_INSERT, 4, 0);
    issue_request(apl_pkg::MODE_INSERT, POS_MAX, 32'sd9);
    issue_request(apl_pkg::MODE_READ, 0, 0);
    issue_request(apl_pkg::MODE_READ, 3, 0);
    issue_request(apl_pkg::MODE_READ, 4, 0);
    issue_request(apl_pkg::MODE_READ, POS_MAX, 0);
    issue_request(apl_pkg::MODE_FIND, POS_MAX, 32'sh7fff_ffff);
    issue_request(apl_pkg::MODE_FIND, 0, 32'sd5);
    // duplicate: find must report the lower index
    issue_request(apl_pkg::MODE_INSERT, 3, -32'sd1);
    issue_request(apl_pkg::MODE_FIND, 0, -32'sd1);
    issue_request(apl_pkg::MODE_DELETE, 5, 0);
    issue_request(apl_pkg::MODE_DELETE, 0, 0);
    issue_request(apl_pkg::MODE_DELETE, POS_MAX, 0);
    issue_request(apl_pkg::MODE_DELETE, 1, 0);
  endtask

  task automatic test_unused_modes();
    logic [2:0] m;
    for (m = MODE_UNUSED_FIRST; m != apl_pkg::MODE_READ; m++)
      issue_request(m, POS_MAX, -32'sd1);
    issue_request(apl_pkg::MODE_CLEAR, POS_MAX, 0);
    issue_request(apl_pkg::MODE_READ, 0, 0);
  endtask

  task automatic test_fill_and_overflow();
    idle_enabled = 1'b0;
    while (shadow_list.size() < CAPACITY)
      issue_request(apl_pkg::MODE_INSERT, $urandom_range(1, shadow_list.size() + 1),
                    $urandom());
    idle_enabled = 1'b1;
    issue_request(apl_pkg::MODE_INSERT, $urandom_range(1, CAPACITY), $urandom());
    issue_request(apl_pkg::MODE_INSERT, CAPACITY + 1, $urandom());
    issue_request(apl_pkg::MODE_INSERT, CAPACITY + 2, $urandom());
    issue_request(apl_pkg::MODE_READ, CAPACITY - 1, 0);
    issue_request(apl_pkg::MODE_READ, CAPACITY, 0);
    issue_request(apl_pkg::MODE_FIND, 0, shadow_list[CAPACITY - 1]);
    issue_request(apl_pkg::MODE_FIND, 0, pick_value());
    // hold off until the pipeline is empty, then drain the list
    wait_for_replies();
    issue_request(apl_pkg::MODE_DELETE, CAPACITY, 0);
    issue_request(apl_pkg::MODE_DELETE, CAPACITY, 0);
    while (shadow_list.size() != 0)
      issue_request(apl_pkg::MODE_DELETE, $urandom_range(1, shadow_list.size()), $urandom());
  endtask

  task automatic test_random_mix(int n_items);
    int i;
    int sel;
    int len;
    for (i = 0; i < n_items; i++) begin
      if (i % 64 == 0) idle_enabled = ($urandom_range(0, 3) != 0);
      len = shadow_list.size();
      sel = $urandom_range(0, 99);
      if (sel < 30)
        issue_request(apl_pkg::MODE_INSERT,
                      ($urandom_range(0, 11) == 0) ? $urandom_range(0, POS_MAX)
                                                   : $urandom_range(1, len + 1),
                      pick_value());
      else if (sel < 50)
        issue_request(apl_pkg::MODE_DELETE, ($urandom_range(0, 11) == 0 || len == 0)
                                            ? $urandom_range(0, POS_MAX)
                                            : $urandom_range(1, len), $urandom());
      else if (sel < 70)
        issue_request(apl_pkg::MODE_READ, ($urandom_range(0, 11) == 0 || len == 0)
                                          ? $urandom_range(0, POS_MAX)
                                          : $urandom_range(0, len - 1), $urandom());
      else if (sel < 96)
        issue_request(apl_pkg::MODE_FIND, $urandom_range(0, POS_MAX), pick_value());
      else if (sel < 97)
        issue_request(apl_pkg::MODE_CLEAR, $urandom_range(0, POS_MAX), $urandom());
      else
        issue_request(3'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
                      $urandom_range(0, POS_MAX), $urandom());
      if (i == n_items / 2) wait_for_replies();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_field_extremes();
    test_unused_modes();
    test_fill_and_overflow();
    test_random_mix(1700);
    wait_for_replies();
    repeat (CAPACITY + 10) @(posedge clk);
    if (error_count == 0) $display("positional_array_list_core: match");
    else $display("positional_array_list_core: mismatch");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("positional_array_list_core: mismatch");
    $finish;
  end

endmodule
